/* sv/icsum_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icsum_pkg
// Shared constants and the ones'-complement add for the IPv4/UDP checksum
// engine.
// ----------------------------------------------------------------------------
package icsum_pkg;

    localparam logic [15:0] PROTO_OFFSET = 16'd9;
    localparam logic [15:0] PSEUDO_START = 16'd12;
    localparam logic [15:0] PSEUDO_END   = 16'd20;
    localparam logic [3:0]  MIN_IHL      = 4'd5;
    localparam logic [3:0]  IPV4_VERSION = 4'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_VERSION = 2'd1;
    localparam logic [1:0] STATUS_LENGTH  = 2'd2;

    typedef logic [15:0] t_word;

    // 16-bit add with end-around carry
    function automatic t_word oc_add(input t_word a, input t_word b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage
`default_nettype wire

/* sv/ipv4_udp_checksum_engine_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_udp_checksum_engine_top
// IPv4 header checksum and UDP checksum (pseudo-header plus segment) over a
// packet that arrives one octet per beat.
//
// Input channel: i_in_valid / o_in_stall carry i_data_byte and i_first;
// i_first marks octet 0 of a packet and restarts all sums.
// Output channel: o_out_valid / i_out_stall carry o_header_sum, o_udp_sum and
// o_status; one beat per packet, after the last octet of the total length,
// or early with an error status (bad version, bad lengths).
// An accepted octet is held in an input register and processed from there;
// the result is then loaded into the output register, whose valid flag
// drives o_out_valid.
// One octet is taken per cycle unless a result octet waits on a stalled
// output; the rate is set by the combinational ones'-complement add
// between the input register and the state/result registers.
// Only an octet that produces a result waits while the output register is
// full and stalled; other octets keep flowing.
// Reset (synchronous, active low) empties both registers and leaves the
// engine idle: octets without i_first are dropped until the next packet.
// ----------------------------------------------------------------------------
module ipv4_udp_checksum_engine_top
    import icsum_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_header_sum,
    output logic [15:0]      o_udp_sum,
    output logic [1:0]       o_status
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_first;

    // packet state
    logic        r_active;
    t_word       r_byte_count;
    logic [3:0]  r_header_words;
    t_word       r_total_length;
    t_word       r_header_acc;
    t_word       r_segment_acc;
    logic [7:0]  r_high_octet;

    // result register
    logic        r_out_valid;
    t_word       r_header_sum;
    t_word       r_udp_sum;
    logic [1:0]  r_status;

    // current view of state (restart on first)
    logic        active;
    t_word       bc;
    logic [3:0]  hw;
    t_word       tl;
    t_word       hacc;
    t_word       sacc;
    logic [7:0]  high;

    logic        idx0;
    logic        ver_bad;
    logic        len_bad;
    logic        is_end;
    logic        odd;
    logic [3:0]  n_header_words;
    t_word       hbytes;
    t_word       n_total_length;
    t_word       word;
    t_word       seg_addend;
    logic        seg_add;
    t_word       n_header_acc;
    t_word       n_segment_acc;
    logic        emit;
    logic        out_free;
    logic        advance;

    assign active = r_first | r_active;
    assign bc     = r_first ? '0 : r_byte_count;
    assign hw     = r_first ? '0 : r_header_words;
    assign tl     = r_first ? '0 : r_total_length;
    assign hacc   = r_first ? '0 : r_header_acc;
    assign sacc   = r_first ? '0 : r_segment_acc;
    assign high   = r_first ? '0 : r_high_octet;

    assign idx0           = (bc == '0);
    assign ver_bad        = idx0 && (r_byte[7:4] != IPV4_VERSION);
    assign n_header_words = idx0 ? r_byte[3:0] : hw;
    assign hbytes         = {10'd0, n_header_words, 2'b00};
    assign odd            = bc[0];
    assign word           = {high, r_byte};

    always_comb begin
        priority if (bc == 16'd2) begin
            n_total_length = {r_byte, 8'd0};
        end else if (bc == 16'd3) begin
            n_total_length = tl | {8'd0, r_byte};
        end else begin
            n_total_length = tl;
        end
    end

    assign len_bad = (bc == 16'd3)
                     && ((n_header_words < MIN_IHL) || (n_total_length < hbytes));
    assign is_end  = (bc >= 16'd3)
                     && (({1'b0, bc} + 17'd1) == {1'b0, n_total_length});

    // at most one segment term per octet on any path that reaches a result
    always_comb begin
        seg_add    = 1'b0;
        seg_addend = '0;
        priority if (bc == 16'd3) begin
            seg_add    = 1'b1;
            seg_addend = n_total_length - hbytes;
        end else if (bc == PROTO_OFFSET) begin
            seg_add    = 1'b1;
            seg_addend = {8'd0, r_byte};
        end else if (!odd) begin
            seg_add    = is_end && (bc >= hbytes);
            seg_addend = {r_byte, 8'd0};
        end else begin
            seg_add    = ((bc >= PSEUDO_START) && (bc < PSEUDO_END)) || (bc >= hbytes);
            seg_addend = word;
        end
    end

    assign n_header_acc  = (odd && (bc < hbytes)) ? oc_add(hacc, word) : hacc;
    assign n_segment_acc = seg_add ? oc_add(sacc, seg_addend) : sacc;

    assign emit     = active && (ver_bad || len_bad || is_end);
    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && (!emit || out_free);

    assign o_in_stall   = r_in_valid && !advance;
    assign o_out_valid  = r_out_valid;
    assign o_header_sum = r_header_sum;
    assign o_udp_sum    = r_udp_sum;
    assign o_status     = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte  <= i_data_byte;
            r_first <= i_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_byte_count   <= '0;
            r_header_words <= '0;
            r_total_length <= '0;
            r_header_acc   <= '0;
            r_segment_acc  <= '0;
            r_high_octet   <= '0;
        end else if (advance && active) begin
            r_active       <= !emit;
            r_byte_count   <= (bc == 16'hFFFF) ? bc : bc + 16'd1;
            r_header_words <= n_header_words;
            r_total_length <= n_total_length;
            r_header_acc   <= n_header_acc;
            r_segment_acc  <= n_segment_acc;
            r_high_octet   <= odd ? high : r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            priority if (ver_bad) begin
                r_header_sum <= '0;
                r_udp_sum    <= '0;
                r_status     <= STATUS_VERSION;
            end else if (len_bad) begin
                r_header_sum <= '0;
                r_udp_sum    <= '0;
                r_status     <= STATUS_LENGTH;
            end else begin
                r_header_sum <= ~n_header_acc;
                r_udp_sum    <= ~n_segment_acc;
                r_status     <= STATUS_OK;
            end
        end
    end

endmodule
`default_nettype wire
